// ===== hw/rtl/banked_framebuffer_pixel_writer_top_defines.svh =====
// assertion macros for the banked framebuffer pixel writer
// included by the top level; no other dependencies
`ifndef BANKED_FRAMEBUFFER_PIXEL_WRITER_TOP_DEFINES_SVH
`define BANKED_FRAMEBUFFER_PIXEL_WRITER_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// antecedent implies consequent in the same cycle
`define BFPW_ASSERT_IMPLY(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define BFPW_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define BFPW_ASSERT_IMPLY(name, clk, rst_n, ante, cons, msg)
`define BFPW_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== hw/rtl/bfpw_pkg.sv =====
// shared types, constants and helper functions of the pixel writer
// used by every module of the block; depends on nothing
`timescale 1ns / 1ps

package bfpw_pkg;

    // design limits
    localparam int MAX_DIM_DEFAULT = 4096;
    localparam int MAX_RESULTS     = 8;
    localparam int SEL_W           = $clog2(MAX_RESULTS);
    localparam logic [SEL_W-1:0] ROOM_PLAIN = SEL_W'(MAX_RESULTS - 1);
    localparam logic [SEL_W-1:0] ROOM_HEAD  = SEL_W'(MAX_RESULTS - 2);

    // configuration port
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 48;

    // register widths
    localparam int PB_W      = 4;
    localparam int LAYOUT_W  = 48;
    localparam int DIM_W     = 13;
    localparam int LGAP_W    = 16;
    localparam int BGAP_W    = 20;
    localparam int LPB_W     = 13;
    localparam int WLAYOUT_W = 32;

    // field widths
    localparam int CH_W     = 8;
    localparam int WIN_W    = 16;
    localparam int OFF_W    = 24;
    localparam int DATA_W   = 64;
    localparam int BCNT_W   = 4;

    // address arithmetic
    localparam int KB_SHIFT  = 10;
    localparam int WS_W      = WIN_W + KB_SHIFT;
    localparam int TOTAL_W   = 21;
    localparam int POS_W     = 25;
    localparam int QUO_W     = POS_W - KB_SHIFT;
    localparam int REM_W     = WIN_W;
    localparam int DIM_CMP_W = 17;

    // stream payloads
    localparam int S_TDATA_W = 3 * CH_W;
    localparam int M_FIELD_W = WIN_W + OFF_W + DATA_W + BCNT_W;
    localparam int M_TDATA_W = ((M_FIELD_W + 7) / 8) * 8;

    // reset values
    localparam logic [PB_W-1:0]      RST_PIXEL_BYTES    = PB_W'(4);
    localparam logic [LAYOUT_W-1:0]  RST_CHANNEL_LAYOUT = '0;
    localparam logic [DIM_W-1:0]     RST_FRAME_WIDTH    = DIM_W'(320);
    localparam logic [DIM_W-1:0]     RST_FRAME_HEIGHT   = DIM_W'(200);
    localparam logic [LGAP_W-1:0]    RST_LINE_GAP       = '0;
    localparam logic [BGAP_W-1:0]    RST_BANK_GAP       = '0;
    localparam logic [LPB_W-1:0]     RST_LINES_PER_BANK = LPB_W'(200);
    localparam logic [WLAYOUT_W-1:0] RST_WINDOW_LAYOUT  = '0;

    // register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_PIXEL_BYTES    = 4'd0,
        REG_CHANNEL_LAYOUT = 4'd1,
        REG_FRAME_WIDTH    = 4'd2,
        REG_FRAME_HEIGHT   = 4'd3,
        REG_LINE_GAP       = 4'd4,
        REG_BANK_GAP       = 4'd5,
        REG_LINES_PER_BANK = 4'd6,
        REG_WINDOW_LAYOUT  = 4'd7
    } cfg_reg_t;

    // result kinds
    typedef enum logic {
        KIND_WRITE  = 1'b0,
        KIND_SELECT = 1'b1
    } kind_t;

    // controller to datapath
    typedef struct packed {
        logic latch_pixel;
        logic prep;
        logic emit_sel0;
        logic emit_write;
        logic div_start;
        logic load_product;
        logic emit_sel;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_free;
        logic head_select;
        logic crossing;
        logic div_busy;
        logic sel_last;
    } sts_t;

    // place one channel: (c >> (8 - size)) << pos, nothing when pos is past the word
    function automatic logic [DATA_W-1:0] pack_channel(input logic [CH_W-1:0] c,
                                                       input logic [7:0] size,
                                                       input logic [7:0] pos);
        logic [3:0]        rsh;
        logic [CH_W-1:0]   v;
        logic [DATA_W-1:0] res;
        rsh = (size >= 8'd8) ? 4'd0 : 4'(8'd8 - size);
        v   = c >> rsh;
        if (pos >= 8'd64) begin
            res = '0;
        end else begin
            res = {{(DATA_W - CH_W){1'b0}}, v} << pos[5:0];
        end
        return res;
    endfunction

    // low pb bytes set
    function automatic logic [DATA_W-1:0] byte_mask(input logic [PB_W-1:0] pb);
        logic [DATA_W-1:0] m;
        for (int i = 0; i < DATA_W / 8; i++) begin
            m[8*i +: 8] = (PB_W'(i) < pb) ? 8'hFF : 8'h00;
        end
        return m;
    endfunction

endpackage

// ===== hw/rtl/bfpw_div.sv =====
// restoring divider, one quotient bit per cycle
// depends on bfpw_pkg for the operand widths
`timescale 1ns / 1ps

module bfpw_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [bfpw_pkg::QUO_W-1:0]    dividend,
    input  logic [bfpw_pkg::REM_W-1:0]    divisor,
    output logic                          busy,
    output logic [bfpw_pkg::QUO_W-1:0]    quotient,
    output logic [bfpw_pkg::REM_W-1:0]    remainder
);

    localparam int QW = bfpw_pkg::QUO_W;
    localparam int RW = bfpw_pkg::REM_W;
    localparam int CNT_W = $clog2(QW + 1);

    logic [RW-1:0]    rem_reg, rem_next;
    logic [QW-1:0]    quo_reg, quo_next;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic [RW:0]      trial;
    logic             ge;

    // one shift-subtract step
    always_comb begin
        trial    = {rem_reg, quo_reg[QW-1]};
        ge       = trial >= {1'b0, divisor};
        rem_next = ge ? RW'(trial - {1'b0, divisor}) : RW'(trial);
        quo_next = {quo_reg[QW-2:0], ge};
    end

    // iteration control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(QW);
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    // partial remainder and quotient
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign busy      = busy_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// ===== hw/rtl/bfpw_datapath.sv =====
// datapath: config registers, raster counters, pixel packing, window math,
// output register; depends on bfpw_pkg and bfpw_div
`timescale 1ns / 1ps

module bfpw_datapath #(
    parameter int MAX_DIM = bfpw_pkg::MAX_DIM_DEFAULT
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration
    input  logic                                cfg_we,
    input  logic [bfpw_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [bfpw_pkg::CFG_DATA_W-1:0]     cfg_data,
    // input pixel
    input  logic [bfpw_pkg::S_TDATA_W-1:0]      pixel,
    // control
    input  bfpw_pkg::cmd_t                      cmd,
    output bfpw_pkg::sts_t                      sts,
    // result register
    input  logic                                out_ready,
    output logic                                out_valid,
    output bfpw_pkg::kind_t                     out_kind,
    output logic [bfpw_pkg::WIN_W-1:0]          out_window_number,
    output logic [bfpw_pkg::OFF_W-1:0]          out_byte_offset,
    output logic [bfpw_pkg::DATA_W-1:0]         out_write_data,
    output logic [bfpw_pkg::BCNT_W-1:0]         out_byte_count,
    output logic                                out_last
);

    localparam int CW     = $clog2(MAX_DIM);
    localparam int CMPW   = bfpw_pkg::DIM_CMP_W;
    localparam int CH_W   = bfpw_pkg::CH_W;
    localparam int PB_W   = bfpw_pkg::PB_W;
    localparam int WIN_W  = bfpw_pkg::WIN_W;
    localparam int OFF_W  = bfpw_pkg::OFF_W;
    localparam int DATA_W = bfpw_pkg::DATA_W;
    localparam int POS_W  = bfpw_pkg::POS_W;
    localparam int TOT_W  = bfpw_pkg::TOTAL_W;
    localparam int QUO_W  = bfpw_pkg::QUO_W;
    localparam int REM_W  = bfpw_pkg::REM_W;
    localparam int KB     = bfpw_pkg::KB_SHIFT;
    localparam int LPB_W  = bfpw_pkg::LPB_W;
    localparam int SEL_W  = bfpw_pkg::SEL_W;

    // configuration registers
    logic [PB_W-1:0]                cfg_pixel_bytes_reg;
    logic [bfpw_pkg::LAYOUT_W-1:0]  cfg_channel_layout_reg;
    logic [bfpw_pkg::DIM_W-1:0]     cfg_frame_width_reg;
    logic [bfpw_pkg::DIM_W-1:0]     cfg_frame_height_reg;
    logic [bfpw_pkg::LGAP_W-1:0]    cfg_line_gap_reg;
    logic [bfpw_pkg::BGAP_W-1:0]    cfg_bank_gap_reg;
    logic [LPB_W-1:0]               cfg_lines_per_bank_reg;
    logic [bfpw_pkg::WLAYOUT_W-1:0] cfg_window_layout_reg;

    // raster and window state
    logic [CW-1:0]    column_reg, column_next;
    logic [CW-1:0]    row_reg, row_next;
    logic [LPB_W-1:0] bank_lines_reg, bank_lines_next;
    logic [WIN_W-1:0] window_index_reg;
    logic [OFF_W-1:0] window_offset_reg;

    // per-item working registers
    logic [CH_W-1:0]   red_reg, green_reg, blue_reg;
    logic [POS_W-1:0]  pos_reg;
    logic [OFF_W-1:0]  write_off_reg;
    logic [DATA_W-1:0] data_reg;
    logic [PB_W-1:0]   pb_out_reg;
    logic              fs_reg;
    logic [WIN_W-1:0]  final_idx_reg;
    logic [WIN_W-1:0]  acc_reg;
    logic [SEL_W-1:0]  sel_i_reg;

    // output register
    logic                       valid_reg;
    bfpw_pkg::kind_t            kind_reg;
    logic [WIN_W-1:0]           win_reg;
    logic [OFF_W-1:0]           off_reg;
    logic [DATA_W-1:0]          wdata_reg;
    logic [bfpw_pkg::BCNT_W-1:0] bcnt_reg;
    logic                       last_reg;

    // derived values
    logic [PB_W-1:0]            pb_eff;
    logic [WIN_W-1:0]           wsk;
    logic [WIN_W-1:0]           step;
    logic [bfpw_pkg::WS_W-1:0]  ws;
    logic                       reloc;
    logic [CMPW-1:0]            max_dim_ext, fw_ext, fh_ext, eff_w, eff_h;
    logic [LPB_W-1:0]           eff_lpb, cur_bank;
    logic [CW:0]                col1, row1;
    logic                       col_wrap, row_wrap, bank_wrap, fs_now;
    logic [TOT_W-1:0]           total;
    logic [OFF_W-1:0]           eff_off;
    logic [POS_W-1:0]           pos;
    logic [DATA_W-1:0]          packed_px;
    logic                       crossing;
    logic                       sel_last;
    logic [SEL_W-1:0]           room;
    logic                       out_free;
    logic                       load;
    logic [QUO_W+WIN_W-1:0]     prod_full;
    logic                       div_busy;
    logic [QUO_W-1:0]           quo;
    logic [REM_W-1:0]           rem;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_pixel_bytes_reg    <= bfpw_pkg::RST_PIXEL_BYTES;
            cfg_channel_layout_reg <= bfpw_pkg::RST_CHANNEL_LAYOUT;
            cfg_frame_width_reg    <= bfpw_pkg::RST_FRAME_WIDTH;
            cfg_frame_height_reg   <= bfpw_pkg::RST_FRAME_HEIGHT;
            cfg_line_gap_reg       <= bfpw_pkg::RST_LINE_GAP;
            cfg_bank_gap_reg       <= bfpw_pkg::RST_BANK_GAP;
            cfg_lines_per_bank_reg <= bfpw_pkg::RST_LINES_PER_BANK;
            cfg_window_layout_reg  <= bfpw_pkg::RST_WINDOW_LAYOUT;
        end else if (cfg_we) begin
            unique case (cfg_index)
                bfpw_pkg::REG_PIXEL_BYTES: begin
                    cfg_pixel_bytes_reg <= cfg_data[PB_W-1:0];
                end
                bfpw_pkg::REG_CHANNEL_LAYOUT: begin
                    cfg_channel_layout_reg <= cfg_data[bfpw_pkg::LAYOUT_W-1:0];
                end
                bfpw_pkg::REG_FRAME_WIDTH: begin
                    cfg_frame_width_reg <= cfg_data[bfpw_pkg::DIM_W-1:0];
                end
                bfpw_pkg::REG_FRAME_HEIGHT: begin
                    cfg_frame_height_reg <= cfg_data[bfpw_pkg::DIM_W-1:0];
                end
                bfpw_pkg::REG_LINE_GAP: begin
                    cfg_line_gap_reg <= cfg_data[bfpw_pkg::LGAP_W-1:0];
                end
                bfpw_pkg::REG_BANK_GAP: begin
                    cfg_bank_gap_reg <= cfg_data[bfpw_pkg::BGAP_W-1:0];
                end
                bfpw_pkg::REG_LINES_PER_BANK: begin
                    cfg_lines_per_bank_reg <= cfg_data[LPB_W-1:0];
                end
                bfpw_pkg::REG_WINDOW_LAYOUT: begin
                    cfg_window_layout_reg <= cfg_data[bfpw_pkg::WLAYOUT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // effective settings after clamping
    always_comb begin
        if (cfg_pixel_bytes_reg == '0) begin
            pb_eff = PB_W'(1);
        end else if (cfg_pixel_bytes_reg > PB_W'(8)) begin
            pb_eff = PB_W'(8);
        end else begin
            pb_eff = cfg_pixel_bytes_reg;
        end
        wsk   = cfg_window_layout_reg[WIN_W-1:0];
        step  = cfg_window_layout_reg[2*WIN_W-1:WIN_W];
        ws    = {wsk, {KB{1'b0}}};
        reloc = wsk != '0;
        max_dim_ext = CMPW'(MAX_DIM);
        fw_ext = CMPW'(cfg_frame_width_reg);
        fh_ext = CMPW'(cfg_frame_height_reg);
        eff_w = (fw_ext == '0) ? CMPW'(1) : ((fw_ext > max_dim_ext) ? max_dim_ext : fw_ext);
        eff_h = (fh_ext == '0) ? CMPW'(1) : ((fh_ext > max_dim_ext) ? max_dim_ext : fh_ext);
        eff_lpb = (cfg_lines_per_bank_reg == '0) ? LPB_W'(1) : cfg_lines_per_bank_reg;
    end

    // raster advance and byte step for the current pixel
    always_comb begin
        fs_now   = (column_reg == '0) && (row_reg == '0);
        cur_bank = fs_now ? eff_lpb : bank_lines_reg;
        col1     = {1'b0, column_reg} + (CW+1)'(1);
        row1     = {1'b0, row_reg} + (CW+1)'(1);
        col_wrap = CMPW'(col1) >= eff_w;
        row_wrap = CMPW'(row1) >= eff_h;
        bank_wrap = cur_bank <= LPB_W'(1);

        column_next     = col_wrap ? '0 : col1[CW-1:0];
        row_next        = row_reg;
        bank_lines_next = cur_bank;
        if (col_wrap) begin
            row_next        = row_wrap ? '0 : row1[CW-1:0];
            bank_lines_next = bank_wrap ? eff_lpb : cur_bank - LPB_W'(1);
        end

        total = TOT_W'(pb_eff)
              + (col_wrap ? TOT_W'(cfg_line_gap_reg) : '0)
              + ((col_wrap && bank_wrap) ? TOT_W'(cfg_bank_gap_reg) : '0);
        eff_off = fs_now ? '0 : window_offset_reg;
        pos     = POS_W'(eff_off) + POS_W'(total);
    end

    // channel packing
    always_comb begin
        packed_px = bfpw_pkg::pack_channel(red_reg, cfg_channel_layout_reg[7:0],
                                           cfg_channel_layout_reg[15:8])
                  | bfpw_pkg::pack_channel(green_reg, cfg_channel_layout_reg[23:16],
                                           cfg_channel_layout_reg[31:24])
                  | bfpw_pkg::pack_channel(blue_reg, cfg_channel_layout_reg[39:32],
                                           cfg_channel_layout_reg[47:40]);
    end

    // window crossing and select bookkeeping
    always_comb begin
        crossing  = reloc && ({1'b0, pos_reg} >= ws);
        room      = fs_reg ? bfpw_pkg::ROOM_HEAD : bfpw_pkg::ROOM_PLAIN;
        sel_last  = (sel_i_reg == room) || (QUO_W'(sel_i_reg) == quo);
        prod_full = {{WIN_W{1'b0}}, quo} * {{QUO_W{1'b0}}, step};
        out_free  = !valid_reg || out_ready;
        load      = cmd.emit_sel0 || cmd.emit_write || cmd.emit_sel;
    end

    // offset divided by window size, in kilobyte units
    bfpw_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.div_start),
        .dividend  (pos_reg[POS_W-1:KB]),
        .divisor   (wsk),
        .busy      (div_busy),
        .quotient  (quo),
        .remainder (rem)
    );

    // pixel capture
    always_ff @(posedge aclk) begin
        if (cmd.latch_pixel) begin
            red_reg   <= pixel[CH_W-1:0];
            green_reg <= pixel[2*CH_W-1:CH_W];
            blue_reg  <= pixel[3*CH_W-1:2*CH_W];
        end
    end

    // per-item working values
    always_ff @(posedge aclk) begin
        if (cmd.prep) begin
            pos_reg       <= pos;
            write_off_reg <= eff_off;
            data_reg      <= packed_px & bfpw_pkg::byte_mask(pb_eff);
            pb_out_reg    <= pb_eff;
            fs_reg        <= fs_now;
        end
        if (cmd.load_product) begin
            final_idx_reg <= window_index_reg + prod_full[WIN_W-1:0];
            acc_reg       <= window_index_reg + step;
        end else if (cmd.emit_sel) begin
            acc_reg <= acc_reg + step;
        end
    end

    // select counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sel_i_reg <= '0;
        end else if (cmd.load_product) begin
            sel_i_reg <= SEL_W'(1);
        end else if (cmd.emit_sel) begin
            sel_i_reg <= sel_i_reg + SEL_W'(1);
        end
    end

    // raster counters, window number and offset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            column_reg        <= '0;
            row_reg           <= '0;
            bank_lines_reg    <= bfpw_pkg::RST_LINES_PER_BANK;
            window_index_reg  <= '0;
            window_offset_reg <= '0;
        end else begin
            if (cmd.prep) begin
                column_reg     <= column_next;
                row_reg        <= row_next;
                bank_lines_reg <= bank_lines_next;
                if (fs_now) begin
                    window_index_reg <= '0;
                end
            end
            if (cmd.emit_write && !crossing) begin
                window_offset_reg <= pos_reg[OFF_W-1:0];
            end
            if (cmd.emit_sel && sel_last) begin
                window_index_reg  <= final_idx_reg;
                window_offset_reg <= OFF_W'({rem, pos_reg[KB-1:0]});
            end
        end
    end

    // result register valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (out_ready) begin
            valid_reg <= 1'b0;
        end
    end

    // result register payload
    always_ff @(posedge aclk) begin
        if (cmd.emit_sel0) begin
            kind_reg  <= bfpw_pkg::KIND_SELECT;
            win_reg   <= '0;
            off_reg   <= '0;
            wdata_reg <= '0;
            bcnt_reg  <= '0;
            last_reg  <= 1'b0;
        end else if (cmd.emit_write) begin
            kind_reg  <= bfpw_pkg::KIND_WRITE;
            win_reg   <= '0;
            off_reg   <= write_off_reg;
            wdata_reg <= data_reg;
            bcnt_reg  <= pb_out_reg;
            last_reg  <= !crossing;
        end else if (cmd.emit_sel) begin
            kind_reg  <= bfpw_pkg::KIND_SELECT;
            win_reg   <= sel_last ? final_idx_reg : acc_reg;
            off_reg   <= '0;
            wdata_reg <= '0;
            bcnt_reg  <= '0;
            last_reg  <= sel_last;
        end
    end

    // status toward the controller
    always_comb begin
        sts.out_free    = out_free;
        sts.head_select = fs_now && reloc;
        sts.crossing    = crossing;
        sts.div_busy    = div_busy;
        sts.sel_last    = sel_last;
    end

    assign out_valid         = valid_reg;
    assign out_kind          = kind_reg;
    assign out_window_number = win_reg;
    assign out_byte_offset   = off_reg;
    assign out_write_data    = wdata_reg;
    assign out_byte_count    = bcnt_reg;
    assign out_last          = last_reg;

endmodule

// ===== hw/rtl/bfpw_ctrl.sv =====
// controller state machine: sequences capture, write, divide and selects
// depends on bfpw_pkg for the command and status structs
`timescale 1ns / 1ps

module bfpw_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  bfpw_pkg::sts_t  sts,
    output bfpw_pkg::cmd_t  cmd
);

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_PREP  = 7'b0000010,
        ST_SEL0  = 7'b0000100,
        ST_WRITE = 7'b0001000,
        ST_DIV   = 7'b0010000,
        ST_MUL   = 7'b0100000,
        ST_SEL   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.latch_pixel = 1'b1;
                    state_next      = ST_PREP;
                end
            end
            ST_PREP: begin
                cmd.prep   = 1'b1;
                state_next = sts.head_select ? ST_SEL0 : ST_WRITE;
            end
            ST_SEL0: begin
                if (sts.out_free) begin
                    cmd.emit_sel0 = 1'b1;
                    state_next    = ST_WRITE;
                end
            end
            ST_WRITE: begin
                if (sts.out_free) begin
                    cmd.emit_write = 1'b1;
                    if (sts.crossing) begin
                        cmd.div_start = 1'b1;
                        state_next    = ST_DIV;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_DIV: begin
                if (!sts.div_busy) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                cmd.load_product = 1'b1;
                state_next       = ST_SEL;
            end
            ST_SEL: begin
                if (sts.out_free) begin
                    cmd.emit_sel = 1'b1;
                    if (sts.sel_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== hw/rtl/banked_framebuffer_pixel_writer_top.sv =====
// Banked framebuffer pixel writer, top level.
// Input stream: one RGB pixel per transfer in raster order. Output stream: pixel
// writes (tuser 0) with offset, packed data and byte count, and window selects
// (tuser 1) carrying the new window number; tlast marks the final result of a pixel.
// Configuration channel: index and data, always ready; it is to be written only
// while idle, which the user must keep to, as the block does not enforce it.
// Each pixel passes capture, address/pack and write; at the start of a frame
// with a relocatable window a select of window 0 leads the write. A window
// crossing adds the 15-step divider that splits the new offset into window
// count and remainder, then the step multiply, then the selects.
// At most 8 results per pixel; surplus intermediate selects are dropped.
// Reset (aresetn low, synchronous) loads the default registers and puts the
// raster at frame start; no memory, no clearing pass.
// A stalled receiver holds the output register; the pipeline waits on it and
// the next pixel is taken as soon as the current one has issued its results.
// Depends on bfpw_pkg, bfpw_div, bfpw_datapath, bfpw_ctrl and the defines header.
`timescale 1ns / 1ps
`include "banked_framebuffer_pixel_writer_top_defines.svh"

module banked_framebuffer_pixel_writer_top #(
    parameter int MAX_DIM = bfpw_pkg::MAX_DIM_DEFAULT
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [bfpw_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [bfpw_pkg::CFG_DATA_W-1:0]     cfg_data,
    // pixel input
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [bfpw_pkg::S_TDATA_W-1:0]      s_axis_tdata,  // red, green, blue
    // results
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // window_number, byte_offset, write_data, byte_count, zero pad
    output logic [bfpw_pkg::M_TDATA_W-1:0]      m_axis_tdata,
    output logic                                m_axis_tuser,  // kind
    output logic                                m_axis_tlast
);

    localparam int WIN_W  = bfpw_pkg::WIN_W;
    localparam int OFF_W  = bfpw_pkg::OFF_W;
    localparam int DATA_W = bfpw_pkg::DATA_W;
    localparam int BCNT_W = bfpw_pkg::BCNT_W;
    localparam int CNT_LSB = WIN_W + OFF_W + DATA_W;
    localparam int CNT_MSB = CNT_LSB + BCNT_W - 1;
    localparam int PAD_W   = bfpw_pkg::M_TDATA_W - bfpw_pkg::M_FIELD_W;

    bfpw_pkg::cmd_t  cmd;
    bfpw_pkg::sts_t  sts;
    bfpw_pkg::kind_t out_kind;
    logic [WIN_W-1:0]  out_win;
    logic [OFF_W-1:0]  out_off;
    logic [DATA_W-1:0] out_data;
    logic [BCNT_W-1:0] out_cnt;

    // configuration is accepted every cycle
    assign cfg_ready = 1'b1;

    bfpw_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    bfpw_datapath #(
        .MAX_DIM (MAX_DIM)
    ) u_datapath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_we            (cfg_valid),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .pixel             (s_axis_tdata),
        .cmd               (cmd),
        .sts               (sts),
        .out_ready         (m_axis_tready),
        .out_valid         (m_axis_tvalid),
        .out_kind          (out_kind),
        .out_window_number (out_win),
        .out_byte_offset   (out_off),
        .out_write_data    (out_data),
        .out_byte_count    (out_cnt),
        .out_last          (m_axis_tlast)
    );

    // result payload packing
    assign m_axis_tdata = {{PAD_W{1'b0}}, out_cnt, out_data, out_off, out_win};
    assign m_axis_tuser = out_kind;

    // checks
    `BFPW_ASSERT_IMPLY(a_emit_needs_room, aclk, aresetn,
        cmd.emit_sel0 || cmd.emit_write || cmd.emit_sel, sts.out_free,
        "result loaded while output register is occupied")
    `BFPW_ASSERT_NEXT(a_div_runs, aclk, aresetn, cmd.div_start, sts.div_busy,
        "divider did not start")
    `BFPW_ASSERT_IMPLY(a_write_count, aclk, aresetn, m_axis_tvalid && !m_axis_tuser,
        m_axis_tdata[CNT_MSB:CNT_LSB] != '0 && m_axis_tdata[CNT_MSB:CNT_LSB] <= 4'd8,
        "pixel write with byte count out of range")
    `BFPW_ASSERT_IMPLY(a_select_clean, aclk, aresetn, m_axis_tvalid && m_axis_tuser,
        m_axis_tdata[bfpw_pkg::M_TDATA_W-1:WIN_W] == '0,
        "window select carries offset, data or count")

endmodule
